// ===== sv/ilse_pkg.sv =====
// Shared types and constants for the indexed list and stack engine.
`timescale 1ns / 1ps

package ilse_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int ELEM_BITS_DEF = 32;

   // request modes
   typedef enum logic [3:0] {
      MODE_APPEND    = 4'd0,
      MODE_GET       = 4'd1,
      MODE_INSERT    = 4'd2,
      MODE_DELETE    = 4'd3,
      MODE_PEEK      = 4'd4,
      MODE_POP       = 4'd5,
      MODE_CLEAR     = 4'd6,
      MODE_FWD_START = 4'd7,
      MODE_REV_START = 4'd8,
      MODE_ITER_NEXT = 4'd9
   } mode_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ERROR   = 2'd1,
      ST_END     = 2'd2,
      ST_CHANGED = 2'd3
   } status_type;

   // which entry the datapath reads for the response word
   typedef enum logic [2:0] {
      RD_NONE        = 3'd0,
      RD_POS         = 3'd1,
      RD_TOP         = 3'd2,
      RD_BELOW_TOP   = 3'd3,
      RD_CURSOR      = 3'd4,
      RD_CURSOR_DOWN = 3'd5
   } rd_sel_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [3:0]  position;
      logic [31:0] new_item;
      logic        return_top;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] item_out;
      logic [4:0]  item_count;
   } rsp_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] mode;
      logic       return_top;
      logic       pos_ok;
      logic       not_full;
      logic       not_empty;
      logic       two_plus;
      logic       changed;
      logic       cur_reverse;
      logic       cur_fwd_ok;
      logic       cur_nonzero;
      logic       cur_down_ok;
   } dp_stat_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       exec;
      logic       do_append;
      logic       do_insert;
      logic       do_delete;
      logic       do_clear;
      logic       do_pop;
      logic       start_fwd;
      logic       start_rev;
      logic       cur_inc;
      logic       cur_dec;
      rd_sel_type rd_sel;
      status_type status;
   } dp_ctl_type;

endpackage

// ===== sv/ilse_ctrl.sv =====
// Controller state machine: handshake sequencing and mode decode.
`timescale 1ns / 1ps

module ilse_ctrl
   import ilse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_ctl_type  ctl
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } ilse_state_type;

   ilse_state_type state_ff, state_in;

   // take a word when idle, or when the held result leaves this cycle
   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_RESP) && rsp_ready);
   assign rsp_valid = (state_ff == S_RESP);

   // advance the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = req_valid ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // decode the held word into datapath operations
   always_comb begin
      ctl           = '0;
      ctl.rd_sel    = RD_NONE;
      ctl.status    = ST_ERROR;
      ctl.load      = req_valid && req_ready;
      ctl.exec      = (state_ff == S_EXEC);
      if (state_ff == S_EXEC) begin
         case (stat.mode)
            MODE_APPEND: begin
               if (stat.not_full) begin
                  ctl.do_append = 1'b1;
                  ctl.status    = ST_OK;
               end
            end
            MODE_GET: begin
               if (stat.pos_ok) begin
                  ctl.rd_sel = RD_POS;
                  ctl.status = ST_OK;
               end
            end
            MODE_INSERT: begin
               if (stat.pos_ok && stat.not_full) begin
                  ctl.do_insert = 1'b1;
                  ctl.status    = ST_OK;
               end
            end
            MODE_DELETE: begin
               if (stat.pos_ok) begin
                  ctl.do_delete = 1'b1;
                  ctl.status    = ST_OK;
               end
            end
            MODE_PEEK: begin
               if (stat.not_empty) begin
                  ctl.rd_sel = RD_TOP;
                  ctl.status = ST_OK;
               end
            end
            MODE_POP: begin
               ctl.do_pop = 1'b1;
               if (!stat.return_top) begin
                  ctl.status = ST_OK;
               end else if (stat.two_plus) begin
                  ctl.rd_sel = RD_BELOW_TOP;
                  ctl.status = ST_OK;
               end
            end
            MODE_CLEAR: begin
               ctl.do_clear = 1'b1;
               ctl.status   = ST_OK;
            end
            MODE_FWD_START: begin
               ctl.start_fwd = 1'b1;
               ctl.status    = ST_OK;
            end
            MODE_REV_START: begin
               ctl.start_rev = 1'b1;
               ctl.status    = ST_OK;
            end
            MODE_ITER_NEXT: begin
               if (stat.changed) begin
                  ctl.status = ST_CHANGED;
               end else if (!stat.cur_reverse) begin
                  if (stat.cur_fwd_ok) begin
                     ctl.rd_sel  = RD_CURSOR;
                     ctl.cur_inc = 1'b1;
                     ctl.status  = ST_OK;
                  end else begin
                     ctl.status = ST_END;
                  end
               end else if (stat.cur_nonzero) begin
                  // list shrank under the cursor: still step down
                  ctl.cur_dec = 1'b1;
                  if (stat.cur_down_ok) begin
                     ctl.rd_sel = RD_CURSOR_DOWN;
                     ctl.status = ST_OK;
                  end
               end else begin
                  ctl.status = ST_END;
               end
            end
            default: begin
               ctl.status = ST_ERROR;
            end
         endcase
      end
   end

endmodule

// ===== sv/ilse_dp.sv =====
// Datapath: element cell row, count, iteration cursor and result register.
`timescale 1ns / 1ps

module ilse_dp
   import ilse_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_ctl_type  ctl,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = CNT_W + 4;

   req_type                req_ff;
   logic [ELEM_BITS-1:0]   store_ff [DEPTH];
   logic [ELEM_BITS-1:0]   from_below [DEPTH];
   logic [ELEM_BITS-1:0]   from_above [DEPTH];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cursor_ff, cursor_in;
   logic                   changed_ff, changed_in;
   logic                   cur_rev_ff, cur_rev_in;
   rsp_type                rsp_ff;
   logic [CMP_W-1:0]       pos_c, count_c;
   logic [CNT_W-1:0]       rd_cnt;
   logic [IDX_W-1:0]       rd_idx;
   logic [ELEM_BITS-1:0]   rd_data;
   logic [ELEM_BITS-1:0]   item_elem;

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
   end

   assign item_elem = ELEM_BITS'(req_ff.new_item);
   assign pos_c     = CMP_W'(req_ff.position);
   assign count_c   = CMP_W'(count_ff);

   // status toward the controller
   always_comb begin
      stat             = '0;
      stat.mode        = req_ff.mode;
      stat.return_top  = req_ff.return_top;
      stat.pos_ok      = pos_c < count_c;
      stat.not_full    = count_ff < CNT_W'(DEPTH);
      stat.not_empty   = count_ff != '0;
      stat.two_plus    = count_ff > CNT_W'(1);
      stat.changed     = changed_ff;
      stat.cur_reverse = cur_rev_ff;
      stat.cur_fwd_ok  = cursor_ff < count_ff;
      stat.cur_nonzero = cursor_ff != '0;
      stat.cur_down_ok = cursor_ff <= count_ff;
   end

   // cell row: each cell loads the new word, its lower or its upper neighbor
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_bottom
         assign from_below[g] = item_elem;
      end else begin : g_mid_lo
         assign from_below[g] = store_ff[g-1];
      end
      if (g == DEPTH - 1) begin : g_top
         assign from_above[g] = store_ff[g];
      end else begin : g_mid_hi
         assign from_above[g] = store_ff[g+1];
      end

      always_ff @(posedge clock) begin
         if (ctl.do_append && (count_c == CMP_W'(g))) begin
            store_ff[g] <= item_elem;
         end else if (ctl.do_insert && (pos_c == CMP_W'(g))) begin
            store_ff[g] <= item_elem;
         end else if (ctl.do_insert && (pos_c < CMP_W'(g))) begin
            store_ff[g] <= from_below[g];
         end else if (ctl.do_delete && (pos_c <= CMP_W'(g))) begin
            store_ff[g] <= from_above[g];
         end
      end
   end

   // pick the read entry
   always_comb begin
      case (ctl.rd_sel)
         RD_POS:         rd_cnt = pos_c[CNT_W-1:0];
         RD_TOP:         rd_cnt = count_ff - CNT_W'(1);
         RD_BELOW_TOP:   rd_cnt = count_ff - CNT_W'(2);
         RD_CURSOR:      rd_cnt = cursor_ff;
         RD_CURSOR_DOWN: rd_cnt = cursor_ff - CNT_W'(1);
         default:        rd_cnt = '0;
      endcase
   end

   assign rd_idx  = rd_cnt[IDX_W-1:0];
   assign rd_data = store_ff[rd_idx];

   // update count, change flag and cursor
   always_comb begin
      count_in   = count_ff;
      changed_in = changed_ff;
      cursor_in  = cursor_ff;
      cur_rev_in = cur_rev_ff;
      if (ctl.do_clear) begin
         count_in   = '0;
         changed_in = 1'b1;
      end
      if (ctl.do_append || ctl.do_insert) begin
         count_in   = count_ff + CNT_W'(1);
         changed_in = 1'b1;
      end
      if (ctl.do_delete) begin
         count_in   = count_ff - CNT_W'(1);
         changed_in = 1'b1;
      end
      if (ctl.do_pop && (count_ff != '0)) count_in = count_ff - CNT_W'(1);
      if (ctl.start_fwd) begin
         cursor_in  = '0;
         cur_rev_in = 1'b0;
         changed_in = 1'b0;
      end
      if (ctl.start_rev) begin
         cursor_in  = count_ff;
         cur_rev_in = 1'b1;
         changed_in = 1'b0;
      end
      if (ctl.cur_inc) cursor_in = cursor_ff + CNT_W'(1);
      if (ctl.cur_dec) cursor_in = cursor_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         changed_ff <= 1'b0;
         cursor_ff  <= '0;
         cur_rev_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         changed_ff <= changed_in;
         cursor_ff  <= cursor_in;
         cur_rev_ff <= cur_rev_in;
      end
   end

   // register the result word
   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_ff.status     <= ctl.status;
         rsp_ff.item_out   <= (ctl.rd_sel == RD_NONE) ? 32'd0 : 32'(rd_data);
         rsp_ff.item_count <= 5'(count_in);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/indexed_list_stack_engine.sv =====
// Top level of the indexed list and stack engine.
//
// An ordered list of up to DEPTH elements, used as an array list and a stack.
// Request channel (req_valid/req_ready/req_data) carries one word per request:
// mode, position, new_item and return_top. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one word per request with
// status, item_out and item_count.
// Sequence: an accepted request is held in a register and decoded in the EXEC
// state, where the cell row shifts for insert/delete and the result register
// loads in that same cycle; the response is then valid in the RESP state. No
// new request is taken while one is being worked on: a new request is taken
// in the cycle the held response leaves.
// Reset (synchronous, active high) empties the list, clears the change flag
// and the iteration cursor; element cells are not cleared.
// When the receiver stalls, the response word is held and no new request
// is taken until it leaves.
`timescale 1ns / 1ps

module indexed_list_stack_engine
   import ilse_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEF,
   parameter int ELEM_BITS = ELEM_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_stat_type stat;
   dp_ctl_type  ctl;

   ilse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   ilse_dp #(
      .DEPTH     (DEPTH),
      .ELEM_BITS (ELEM_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // an accepted word is worked on in the decode state before its result shows
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!rsp_valid && !req_ready))
      else $error("request accepted while a result was being formed");

   // no element word rides with a non-ok status
   a_item_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.item_out == 32'd0))
      else $error("item_out nonzero with non-ok status");

   // count never exceeds the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.item_count) <= 32'(DEPTH)))
      else $error("item_count above depth");

   // a response follows its request after the decode cycle
   a_exec_to_resp: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |=> rsp_valid)
      else $error("decode cycle not followed by a response");

endmodule

// ===== verif/indexed_list_stack_engine_test.sv =====
// Self-checking testbench for the indexed list and stack engine.
`timescale 1ns / 1ps

module indexed_list_stack_engine_test;
   import ilse_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_ITEMS = 500;
   localparam int          QUIET_AFTER  = 420;
   localparam int          DRAIN_CYCLES = 8;
   localparam logic [3:0]  MODE_UNDEF_LO = 4'd10;
   localparam logic [3:0]  MODE_UNDEF_HI = 4'd15;

   // Mirror of the list contents; predicts one response word per request word.
   class list_scoreboard;
      logic [31:0] cells [DEPTH_DEF];
      logic [4:0]  count_q;
      logic        changed_q;
      logic [5:0]  cursor_q;
      logic        reverse_q;
      rsp_type     expected_responses [$];
      int          errors;

      function void clear_state();
         foreach (cells[k]) cells[k] = '0;
         count_q   = '0;
         changed_q = 1'b0;
         cursor_q  = '0;
         reverse_q = 1'b0;
         errors    = 0;
      endfunction

      function rsp_type predict_response(req_type r);
         rsp_type     p;
         status_type  st;
         logic [31:0] val;
         st  = ST_ERROR;
         val = '0;
         case (r.mode)
            MODE_APPEND: begin
               if (count_q < DEPTH_DEF) begin
                  cells[count_q] = r.new_item;
                  count_q++;
                  changed_q = 1'b1;
                  st = ST_OK;
               end
            end
            MODE_GET: begin
               if (r.position < count_q) begin
                  val = cells[r.position];
                  st  = ST_OK;
               end
            end
            MODE_INSERT: begin
               // open a slot at the position, later entries move up
               if (r.position < count_q && count_q < DEPTH_DEF) begin
                  for (int k = count_q; k > r.position; k--) cells[k] = cells[k-1];
                  cells[r.position] = r.new_item;
                  count_q++;
                  changed_q = 1'b1;
                  st = ST_OK;
               end
            end
            MODE_DELETE: begin
               // close the gap, later entries move down
               if (r.position < count_q) begin
                  for (int k = r.position; k + 1 < count_q; k++) cells[k] = cells[k+1];
                  count_q--;
                  changed_q = 1'b1;
                  st = ST_OK;
               end
            end
            MODE_PEEK: begin
               if (count_q > 0) begin
                  val = cells[count_q-1];
                  st  = ST_OK;
               end
            end
            MODE_POP: begin
               if (count_q > 0) count_q--;
               if (!r.return_top) begin
                  st = ST_OK;
               end else if (count_q > 0) begin
                  val = cells[count_q-1];
                  st  = ST_OK;
               end
            end
            MODE_CLEAR: begin
               count_q   = '0;
               changed_q = 1'b1;
               st = ST_OK;
            end
            MODE_FWD_START: begin
               cursor_q  = '0;
               reverse_q = 1'b0;
               changed_q = 1'b0;
               st = ST_OK;
            end
            MODE_REV_START: begin
               cursor_q  = 6'(count_q);
               reverse_q = 1'b1;
               changed_q = 1'b0;
               st = ST_OK;
            end
            MODE_ITER_NEXT: begin
               if (changed_q) begin
                  st = ST_CHANGED;
               end else if (!reverse_q) begin
                  if (cursor_q < count_q) begin
                     val = cells[cursor_q];
                     cursor_q++;
                     st = ST_OK;
                  end else begin
                     st = ST_END;
                  end
               end else if (cursor_q > 0) begin
                  // pops may have left the cursor above the list
                  cursor_q--;
                  if (cursor_q < count_q) begin
                     val = cells[cursor_q];
                     st  = ST_OK;
                  end
               end else begin
                  st = ST_END;
               end
            end
            default: st = ST_ERROR;
         endcase
         p.status     = st;
         p.item_out   = val;
         p.item_count = count_q;
         return p;
      endfunction

      function void note_request(req_type r);
         expected_responses.push_back(predict_response(r));
      endfunction

      function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: response with none expected, actual %0h", $time, got);
            return;
         end
         exp_rsp = expected_responses.pop_front();
         if (got.status !== exp_rsp.status)
            report("status", 32'(exp_rsp.status), 32'(got.status));
         if (got.item_out !== exp_rsp.item_out)
            report("item_out", exp_rsp.item_out, got.item_out);
         if (got.item_count !== exp_rsp.item_count)
            report("item_count", 32'(exp_rsp.item_count), 32'(got.item_count));
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   list_scoreboard board;
   int             issued;
   int             cycles;
   bit             quiet;
   bit             idle_on;

   indexed_list_stack_engine i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // check every response word taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: stall in random bursts, starting no new burst once the run goes quiet
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
         end
      end
   end

   // present one request word, hold it until taken, then record it
   task automatic send_request(input req_type r);
      int gap;
      gap = (idle_on && !quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      issued++;
   endtask

   task automatic issue(input logic [3:0] mode, input logic [3:0] pos,
                        input logic [31:0] val, input logic rt);
      req_type r;
      r.mode       = mode;
      r.position   = pos;
      r.new_item   = val;
      r.return_top = rt;
      send_request(r);
   endtask

   // hold off the sender until every response word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_responses.size() != 0) @(negedge clock);
   endtask

   // mostly a position inside the list, sometimes any position
   function automatic logic [3:0] pick_position();
      if (board.count_q > 0 && $urandom_range(0, 3) != 0)
         return 4'($urandom_range(0, board.count_q - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // fill the store, then hit it while full
   task automatic run_fill();
      while (board.count_q < DEPTH_DEF) issue(MODE_APPEND, pick_position(), $urandom, coin());
      issue(MODE_APPEND, pick_position(), $urandom, coin());
      issue(MODE_INSERT, pick_position(), $urandom, coin());
      issue(MODE_GET, 4'd15, $urandom, coin());
      issue(MODE_PEEK, pick_position(), $urandom, coin());
      issue(MODE_POP, pick_position(), $urandom, 1'b1);
   endtask

   task automatic run_list_change();
      case ($urandom_range(0, 3))
         0: issue(MODE_APPEND, pick_position(), $urandom, coin());
         1: issue(MODE_INSERT, pick_position(), $urandom, coin());
         2: issue(MODE_DELETE, pick_position(), $urandom, coin());
         default: issue(MODE_CLEAR, pick_position(), $urandom, coin());
      endcase
   endtask

   // iterate one way past the end, with the odd change or pop on the way
   task automatic run_walk(input logic reverse);
      int steps;
      issue(reverse ? MODE_REV_START : MODE_FWD_START, pick_position(), $urandom, coin());
      steps = board.count_q + 2;
      repeat (steps) begin
         if ($urandom_range(0, 9) == 0) begin
            if (reverse || coin()) issue(MODE_POP, pick_position(), $urandom, coin());
            else run_list_change();
         end
         issue(MODE_ITER_NEXT, pick_position(), $urandom, coin());
      end
   endtask

   // random list and stack work, positions mostly valid
   task automatic run_mix();
      repeat ($urandom_range(4, 12)) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3: issue(MODE_APPEND, pick_position(), $urandom, coin());
            4, 5, 6:    issue(MODE_GET, pick_position(), $urandom, coin());
            7, 8, 9:    issue(MODE_INSERT, pick_position(), $urandom, coin());
            10, 11, 12: issue(MODE_DELETE, pick_position(), $urandom, coin());
            13, 14:     issue(MODE_PEEK, pick_position(), $urandom, coin());
            15, 16, 17: issue(MODE_POP, pick_position(), $urandom, coin());
            18:         issue(MODE_CLEAR, pick_position(), $urandom, coin());
            default:    issue(MODE_ITER_NEXT, pick_position(), $urandom, coin());
         endcase
      end
   endtask

   // pop down to empty and once more
   task automatic run_drain();
      while (board.count_q > 0) issue(MODE_POP, pick_position(), $urandom, coin());
      issue(MODE_POP, pick_position(), $urandom, coin());
   endtask

   // any field value, undefined modes included
   task automatic run_noise();
      repeat ($urandom_range(1, 4))
         issue(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), $urandom, coin());
   endtask

   initial begin
      int first_random;
      int next_pause;
      board = new;
      board.clear_state();
      issued    = 0;
      quiet     = 1'b0;
      idle_on   = 1'b1;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corners
      issue(MODE_PEEK, 4'd0, 32'h0, 1'b0);
      issue(MODE_POP, 4'd0, 32'h0, 1'b1);
      issue(MODE_POP, 4'd0, 32'h0, 1'b0);
      issue(MODE_GET, 4'd0, 32'h0, 1'b0);
      issue(MODE_DELETE, 4'd0, 32'h0, 1'b0);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      // build, insert at both ends of the valid range, reject at the count
      issue(MODE_APPEND, 4'd15, 32'h0000_0000, 1'b1);
      issue(MODE_APPEND, 4'd0, 32'hFFFF_FFFF, 1'b0);
      issue(MODE_INSERT, 4'd0, 32'hA5A5_A5A5, 1'b0);
      issue(MODE_INSERT, 4'd2, 32'h5A5A_5A5A, 1'b1);
      issue(MODE_INSERT, 4'd4, 32'h1111_1111, 1'b0);
      issue(MODE_GET, 4'd15, 32'h0, 1'b0);
      issue(MODE_GET, 4'd3, 32'h0, 1'b0);
      issue(MODE_DELETE, 4'd1, 32'h0, 1'b0);
      // forward walk broken by an append
      issue(MODE_FWD_START, 4'd0, 32'h0, 1'b0);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      issue(MODE_APPEND, 4'd0, 32'h1234_5678, 1'b0);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      // reverse walk with the list popped below the cursor
      issue(MODE_REV_START, 4'd0, 32'h0, 1'b0);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      issue(MODE_POP, 4'd0, 32'h0, 1'b0);
      issue(MODE_POP, 4'd0, 32'h0, 1'b1);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      issue(MODE_UNDEF_LO, 4'd0, 32'h0, 1'b0);
      issue(MODE_UNDEF_HI, 4'd15, 32'hFFFF_FFFF, 1'b1);
      issue(MODE_CLEAR, 4'd0, 32'h0, 1'b0);
      issue(MODE_ITER_NEXT, 4'd0, 32'h0, 1'b0);
      wait_drained();

      // random sequences, the first one fills the store
      first_random = issued;
      next_pause   = 150;
      run_fill();
      while (issued - first_random < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 2) != 0);
         quiet   = (issued - first_random >= QUIET_AFTER);
         case ($urandom_range(0, 9))
            0:       run_fill();
            1, 2:    run_walk(1'b0);
            3, 4:    run_walk(1'b1);
            5, 6, 7: run_mix();
            8:       run_drain();
            default: run_noise();
         endcase
         if (!quiet && issued - first_random >= next_pause) begin
            wait_drained();
            next_pause += 150;
         end
      end

      // let the last response words arrive
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.expected_responses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ilse_pkg.sv
sv/ilse_ctrl.sv
sv/ilse_dp.sv
sv/indexed_list_stack_engine.sv
verif/indexed_list_stack_engine_test.sv
